// ===== design/sliding_window_congestion_sender_core_defines.svh =====
// assertion macros for the sliding window sender core
// needs clk_i and rst_ni in the scope of each use
`ifndef SLIDING_WINDOW_CONGESTION_SENDER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_CONGESTION_SENDER_CORE_DEFINES_SVH

// same-cycle implication
`define SWCS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swcs check failed");

// next-cycle implication
`define SWCS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swcs check failed");

`endif

// ===== design/swcs_pkg.sv =====
// types, constants and codes shared by the sender core
// no dependencies
package swcs_pkg;

  localparam int unsigned MAX_PAYLOAD = 509;
  localparam int unsigned CNT_W       = 20;
  localparam int unsigned LEN_W       = 28;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PLEN_W      = 9;
  localparam int unsigned SEQ_W       = 8;
  localparam int unsigned WIN_W       = 8;
  localparam int unsigned THR_W       = 7;
  localparam int unsigned RWD_W       = 16;
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DVS_W       = 9;

  // reciprocal of the payload size, exact for every 28-bit length
  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned PROD_W    = 57;
  localparam int unsigned RECIP_SH  = 37;
  localparam logic [RECIP_W-1:0] PAY_RECIP = 29'd270017591;

  localparam logic [7:0] ACK_TYPE   = 8'h01;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;
  localparam logic [0:0] CFG_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_THRESH  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_RECV  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_ADVANCE = 3'd1,
    OUT_DUP     = 3'd2,
    OUT_FAST    = 3'd3,
    OUT_TIMEOUT = 3'd4,
    OUT_ERROR   = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RECV,
    BK_DIV,
    BK_START
  } back_state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
    logic              ack_ok;
    logic [SEQ_W-1:0]  seq;
  } item_t;

  typedef struct packed {
    logic              send_valid;
    logic [CNT_W-1:0]  packet_index;
    logic [SEQ_W-1:0]  seq_number;
    logic [PLEN_W-1:0] payload_len;
    logic              last_packet;
    outcome_e          outcome;
    logic              done_res;
    logic [WIN_W-1:0]  window;
    logic [THR_W-1:0]  threshold;
    logic [RWD_W-1:0]  rewinds;
  } result_t;

endpackage

// ===== design/swcs_front.sv =====
// front end: classifies commands, checks acknowledgement sums, queues words
// depends on swcs_pkg
module swcs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [swcs_pkg::LEN_W-1:0] msg_length_i,
  input  logic [31:0]                now_i,
  input  logic                       rx_received_i,
  input  logic [7:0]                 rx_check_i,
  input  logic [7:0]                 rx_type_i,
  input  logic [7:0]                 rx_seq_i,
  output logic                       q_valid_o,
  output swcs_pkg::item_t            q_item_o,
  input  logic                       q_pop_i
);
  import swcs_pkg::*;

  item_t      fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic [8:0] s1, s2;
  logic [7:0] f1, f2;
  item_t      item;
  logic       push;

  always_comb begin
    s1 = {1'b0, rx_check_i} + {1'b0, rx_type_i};
    f1 = s1[7:0] + {7'd0, s1[8]};
    s2 = {1'b0, f1} + {1'b0, rx_seq_i};
    f2 = s2[7:0] + {7'd0, s2[8]};
    item.cmd    = cmd_e'(cmd_i);
    item.len    = msg_length_i;
    item.now    = now_i;
    item.ack_ok = rx_received_i && (f2 == SUM_GOOD) && (rx_type_i == ACK_TYPE);
    item.seq    = rx_seq_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== design/swcs_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on swcs_pkg
module swcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swcs_pkg::DIV_W-1:0] dividend_i,
  input  logic [swcs_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [swcs_pkg::DVS_W-1:0] rem_o
);
  import swcs_pkg::*;

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   tr, nr;
  logic             ge;

  always_comb begin
    tr = {rem_q, quo_q[DIV_W-1]};
    ge = (tr >= {1'b0, dvs_q});
    nr = ge ? (tr - {1'b0, dvs_q}) : tr;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= nr[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/swcs_back.sv =====
// back end: window state, send time store, result register
// depends on swcs_pkg, swcs_div and the assertion macro header
`include "sliding_window_congestion_sender_core_defines.svh"
module swcs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_data_i,
  input  logic                       q_valid_i,
  input  swcs_pkg::item_t            q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output swcs_pkg::result_t          res_o
);
  import swcs_pkg::*;

  back_state_e       st_q, st_d;
  logic [31:0]       tlim_q;
  logic [THR_W-1:0]  ithr_q;
  logic [WIN_W-1:0]  cwnd_q, cwnd_d;
  logic [THR_W-1:0]  ssth_q, ssth_d;
  logic [31:0]       avoid_q, avoid_d;
  logic [CNT_W-1:0]  sent_q, sent_d, acked_q, acked_d, total_q, total_d;
  logic [PLEN_W-1:0] tail_q, tail_d;
  logic [1:0]        dup_q, dup_d;
  logic              armed_q, armed_d;
  logic [RWD_W-1:0]  rwd_q, rwd_d;
  item_t             cur_q;
  logic [CNT_W-1:0]  split_q;
  logic [31:0]       mem [256];
  logic [31:0]       rd_q;
  logic              mem_we;
  result_t           res_q, res_d;
  logic              out_valid_q, fin;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_a;
  logic [DVS_W-1:0]  div_b, div_rem;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  rem_w;
  logic [CNT_W-1:0]  outst, tot;
  logic [1:0]        dup_inc;
  logic              pending, match, last;
  logic [31:0]       age;
  logic [WIN_W-1:0]  half;

  swcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    st_d      = st_q;
    cwnd_d    = cwnd_q;
    ssth_d    = ssth_q;
    avoid_d   = avoid_q;
    sent_d    = sent_q;
    acked_d   = acked_q;
    total_d   = total_q;
    tail_d    = tail_q;
    dup_d     = dup_q;
    armed_d   = armed_q;
    rwd_d     = rwd_q;
    q_pop_o   = 1'b0;
    fin       = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    div_a     = avoid_q + 32'd1;
    div_b     = {1'b0, cwnd_q};
    res_d     = '0;
    res_d.outcome = OUT_NONE;
    outst   = sent_q - acked_q;
    last    = ((sent_q + CNT_W'(1)) == total_q);
    pending = (sent_q != acked_q);
    match   = pending && (cur_q.seq == acked_q[7:0]);
    dup_inc = armed_q ? (dup_q + 2'd1) : dup_q;
    age     = cur_q.now - rd_q;
    half    = cwnd_q >> 1;
    prod    = PROD_W'(q_item_i.len) * PROD_W'(PAY_RECIP);
    rem_w   = cur_q.len - (LEN_W'(split_q) * LEN_W'(MAX_PAYLOAD));
    tot     = split_q + {{(CNT_W-1){1'b0}}, (rem_w != '0)};

    case (st_q)
      BK_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          case (q_item_i.cmd)
            CMD_START: begin
              st_d = BK_START;
            end
            CMD_PULL: begin
              fin = 1'b1;
              if (({{(CNT_W-WIN_W){1'b0}}, cwnd_q} > outst) && (sent_q != total_q)) begin
                mem_we                = 1'b1;
                res_d.send_valid      = 1'b1;
                res_d.packet_index    = sent_q;
                res_d.seq_number      = sent_q[SEQ_W-1:0];
                res_d.payload_len     = last ? tail_q : PLEN_W'(MAX_PAYLOAD);
                res_d.last_packet     = last;
                sent_d                = sent_q + CNT_W'(1);
              end
            end
            CMD_RECV: begin
              st_d = BK_RECV;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      BK_START: begin
        fin     = 1'b1;
        st_d    = BK_IDLE;
        total_d = tot;
        tail_d  = (rem_w != '0) ? rem_w[PLEN_W-1:0] :
                  ((split_q != '0) ? PLEN_W'(MAX_PAYLOAD) : '0);
        cwnd_d  = WIN_W'(1);
        ssth_d  = ithr_q;
        avoid_d = {{(32-THR_W){1'b0}}, ithr_q} + 32'd1;
        sent_d  = '0;
        acked_d = '0;
        dup_d   = 2'd0;
        armed_d = 1'b0;
        rwd_d   = '0;
      end
      BK_RECV: begin
        if (cur_q.ack_ok && match) begin
          acked_d = acked_q + CNT_W'(1);
          rwd_d   = '0;
          dup_d   = 2'd0;
          armed_d = 1'b1;
          if (cwnd_q <= {1'b0, ssth_q}) begin
            cwnd_d        = cwnd_q + WIN_W'(1);
            res_d.outcome = OUT_ADVANCE;
            fin           = 1'b1;
            st_d          = BK_IDLE;
          end else begin
            avoid_d   = avoid_q + 32'd1;
            div_start = 1'b1;
            st_d      = BK_DIV;
          end
        end else begin
          fin  = 1'b1;
          st_d = BK_IDLE;
          if (cur_q.ack_ok && !(dup_inc == 2'd3) && !(pending && (age > tlim_q))) begin
            dup_d         = dup_inc;
            res_d.outcome = OUT_DUP;
          end else begin
            ssth_d  = half[THR_W-1:0];
            avoid_d = {{(32-THR_W){1'b0}}, half[THR_W-1:0]} + 32'd1;
            sent_d  = acked_q;
            dup_d   = 2'd0;
            armed_d = 1'b0;
            if (rwd_q != {RWD_W{1'b1}}) begin
              rwd_d = rwd_q + RWD_W'(1);
            end
            if (!cur_q.ack_ok) begin
              cwnd_d        = WIN_W'(1);
              res_d.outcome = OUT_ERROR;
            end else if (dup_inc == 2'd3) begin
              cwnd_d        = half + WIN_W'(3);
              res_d.outcome = OUT_FAST;
            end else begin
              cwnd_d        = WIN_W'(1);
              res_d.outcome = OUT_TIMEOUT;
            end
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          fin  = 1'b1;
          st_d = BK_IDLE;
          res_d.outcome = OUT_ADVANCE;
          if ((div_rem == '0) && (cwnd_q != {WIN_W{1'b1}}) && (cwnd_q != '0)) begin
            cwnd_d = cwnd_q + WIN_W'(1);
          end
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase

    res_d.done_res  = (acked_d == total_d);
    res_d.window    = cwnd_d;
    res_d.threshold = ssth_d;
    res_d.rewinds   = rwd_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[sent_q[7:0]] <= q_item_i.now;
    end
    rd_q <= mem[acked_q[7:0]];
    if (q_pop_o) begin
      cur_q   <= q_item_i;
      split_q <= prod[RECIP_SH +: CNT_W];
    end
    if (fin) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      tlim_q      <= 32'd50000;
      ithr_q      <= THR_W'(64);
      cwnd_q      <= WIN_W'(1);
      ssth_q      <= THR_W'(64);
      avoid_q     <= 32'd65;
      sent_q      <= '0;
      acked_q     <= '0;
      total_q     <= '0;
      tail_q      <= '0;
      dup_q       <= 2'd0;
      armed_q     <= 1'b0;
      rwd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cwnd_q  <= cwnd_d;
      ssth_q  <= ssth_d;
      avoid_q <= avoid_d;
      sent_q  <= sent_d;
      acked_q <= acked_d;
      total_q <= total_d;
      tail_q  <= tail_d;
      dup_q   <= dup_d;
      armed_q <= armed_d;
      rwd_q   <= rwd_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT: tlim_q <= cfg_data_i;
          CFG_THRESH:  ithr_q <= cfg_data_i[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `SWCS_ASSERT_IMP(a_send_no_outcome, out_valid_q && res_q.send_valid, res_q.outcome == OUT_NONE)
  `SWCS_ASSERT_IMP(a_window_nonzero, out_valid_q, res_q.window != '0)
  `SWCS_ASSERT_NXT(a_taken_clears, out_valid_q && !out_stall_i, !out_valid_q)

endmodule

// ===== design/sliding_window_congestion_sender_core.sv =====
// channel  | handshake                 | word
// input    | in_valid_i / in_stall_o   | cmd, msg_length, now, rx_* fields
// output   | out_valid_o / out_stall_i | packet fields, outcome, window state
// config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
// pull and unknown commands finish in the idle state, start and receive in their own state,
// congestion-avoidance acks also wait for the 32-step divider in the back end
// a two-word queue lets input be taken while the back end works or stalls
// a result waits in the output register; the back end holds until it is taken
// reset is asynchronous, active low; no clearing pass
module sliding_window_congestion_sender_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [27:0] msg_length_i,
  input  logic [31:0] now_i,
  input  logic        rx_received_i,
  input  logic [7:0]  rx_check_i,
  input  logic [7:0]  rx_type_i,
  input  logic [7:0]  rx_seq_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic [19:0] packet_index_o,
  output logic [7:0]  seq_number_o,
  output logic [8:0]  payload_len_o,
  output logic        last_packet_o,
  output logic [2:0]  outcome_o,
  output logic        done_res_o,
  output logic [7:0]  window_o,
  output logic [6:0]  threshold_o,
  output logic [15:0] rewinds_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import swcs_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  swcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .msg_length_i  (msg_length_i),
    .now_i         (now_i),
    .rx_received_i (rx_received_i),
    .rx_check_i    (rx_check_i),
    .rx_type_i     (rx_type_i),
    .rx_seq_i      (rx_seq_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  swcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign send_valid_o   = res.send_valid;
  assign packet_index_o = res.packet_index;
  assign seq_number_o   = res.seq_number;
  assign payload_len_o  = res.payload_len;
  assign last_packet_o  = res.last_packet;
  assign outcome_o      = res.outcome;
  assign done_res_o     = res.done_res;
  assign window_o       = res.window;
  assign threshold_o    = res.threshold;
  assign rewinds_o      = res.rewinds;

endmodule

// ===== sim/swcs_checker.sv =====
// checker for the sliding window sender core: watches both channels and the config port
// keeps its own sender state, queues the expected response words and compares them
// depends on swcs_pkg
`timescale 1ns / 1ps

module swcs_checker
  import swcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [27:0] msg_length_i,
  input  logic [31:0] now_i,
  input  logic        rx_received_i,
  input  logic [7:0]  rx_check_i,
  input  logic [7:0]  rx_type_i,
  input  logic [7:0]  rx_seq_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        send_valid_i,
  input  logic [19:0] packet_index_i,
  input  logic [7:0]  seq_number_i,
  input  logic [8:0]  payload_len_i,
  input  logic        last_packet_i,
  input  logic [2:0]  outcome_i,
  input  logic        done_res_i,
  input  logic [7:0]  window_i,
  input  logic [6:0]  threshold_i,
  input  logic [15:0] rewinds_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o
);

  logic [31:0] timeout_ticks;
  logic [6:0]  start_thresh;
  logic [7:0]  cwnd;
  logic [6:0]  ssthresh;
  logic [31:0] avoid_cnt;
  logic [19:0] sent_cnt, acked_cnt, total_pkts;
  logic [8:0]  tail_len;
  logic [1:0]  dup_cnt;
  logic        dup_armed;
  logic [15:0] rewind_cnt;
  logic [31:0] send_stamp [256];
  result_t     pending_responses [$];
  int          mismatches;

  assign errors_o = mismatches + pending_responses.size();

  function automatic logic ack_sum_holds(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [8:0] sum;
    sum = 9'd0;
    sum = sum + a;
    if (sum[8]) sum = {1'b0, sum[7:0]} + 9'd1;
    sum = sum + b;
    if (sum[8]) sum = {1'b0, sum[7:0]} + 9'd1;
    sum = sum + c;
    if (sum[8]) sum = {1'b0, sum[7:0]} + 9'd1;
    return sum[7:0] == SUM_GOOD;
  endfunction

  task automatic rewind_window(logic [7:0] new_cwnd);
    ssthresh   = 7'(cwnd / 2);
    cwnd       = new_cwnd;
    avoid_cnt  = 32'(ssthresh) + 32'd1;
    sent_cnt   = acked_cnt;
    dup_cnt    = 2'd0;
    dup_armed  = 1'b0;
    if (rewind_cnt != 16'hFFFF) rewind_cnt = rewind_cnt + 16'd1;
  endtask

  task automatic sender_step();
    result_t     r;
    logic [31:0] tot;
    logic [19:0] outstanding;
    logic        is_last, ack_good, pending;
    r = '0;
    r.outcome = OUT_NONE;
    case (cmd_e'(cmd_i))
      CMD_START: begin
        tot = 32'(msg_length_i) / MAX_PAYLOAD + ((32'(msg_length_i) % MAX_PAYLOAD) != 0);
        total_pkts = tot[19:0];
        tail_len   = (tot != 0) ? 9'(32'(msg_length_i) - (tot - 32'd1) * MAX_PAYLOAD) : 9'd0;
        cwnd       = 8'd1;
        ssthresh   = start_thresh;
        avoid_cnt  = 32'(ssthresh) + 32'd1;
        sent_cnt   = '0;
        acked_cnt  = '0;
        dup_cnt    = '0;
        dup_armed  = 1'b0;
        rewind_cnt = '0;
      end
      CMD_PULL: begin
        outstanding = sent_cnt - acked_cnt;
        if (outstanding < 20'(cwnd) && sent_cnt != total_pkts) begin
          is_last = (sent_cnt + 20'd1) == total_pkts;
          r.send_valid   = 1'b1;
          r.packet_index = sent_cnt;
          r.seq_number   = sent_cnt[7:0];
          r.payload_len  = is_last ? tail_len : 9'(MAX_PAYLOAD);
          r.last_packet  = is_last;
          send_stamp[sent_cnt[7:0]] = now_i;
          sent_cnt = sent_cnt + 20'd1;
        end
      end
      CMD_RECV: begin
        ack_good = rx_received_i && ack_sum_holds(rx_check_i, rx_type_i, rx_seq_i) &&
                   rx_type_i == ACK_TYPE;
        if (ack_good) begin
          pending = sent_cnt != acked_cnt;
          if (dup_armed) dup_cnt = dup_cnt + 2'd1;
          if (pending && rx_seq_i == acked_cnt[7:0]) begin
            if (cwnd <= 8'(ssthresh)) begin
              cwnd = cwnd + 8'd1;
            end else begin
              avoid_cnt = avoid_cnt + 32'd1;
              if (cwnd != 0 && avoid_cnt % 32'(cwnd) == 0 && cwnd < 8'd255) cwnd = cwnd + 8'd1;
            end
            acked_cnt  = acked_cnt + 20'd1;
            rewind_cnt = '0;
            dup_cnt    = '0;
            dup_armed  = 1'b1;
            r.outcome  = OUT_ADVANCE;
          end else if (dup_cnt == 2'd3) begin
            rewind_window(8'(cwnd / 2) + 8'd3);
            r.outcome = OUT_FAST;
          end else if (pending && (now_i - send_stamp[acked_cnt[7:0]]) > timeout_ticks) begin
            rewind_window(8'd1);
            r.outcome = OUT_TIMEOUT;
          end else begin
            r.outcome = OUT_DUP;
          end
        end else begin
          rewind_window(8'd1);
          r.outcome = OUT_ERROR;
        end
      end
      default: ;
    endcase
    r.done_res  = acked_cnt == total_pkts;
    r.window    = cwnd;
    r.threshold = ssthresh;
    r.rewinds   = rewind_cnt;
    pending_responses.push_back(r);
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      timeout_ticks = 32'd50000;
      start_thresh  = 7'd64;
      cwnd          = 8'd1;
      ssthresh      = 7'd64;
      avoid_cnt     = 32'd65;
      sent_cnt      = '0;
      acked_cnt     = '0;
      total_pkts    = '0;
      tail_len      = '0;
      dup_cnt       = '0;
      dup_armed     = 1'b0;
      rewind_cnt    = '0;
      for (int i = 0; i < 256; i++) send_stamp[i] = '0;
      pending_responses.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMEOUT) timeout_ticks = cfg_data_i;
        else start_thresh = cfg_data_i[6:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_responses.size() == 0) begin
          report("unexpected word", 32'd1, 32'd0);
        end else begin
          want = pending_responses.pop_front();
          if (send_valid_i !== want.send_valid)
            report("send_valid", 32'(send_valid_i), 32'(want.send_valid));
          if (packet_index_i !== want.packet_index)
            report("packet_index", 32'(packet_index_i), 32'(want.packet_index));
          if (seq_number_i !== want.seq_number)
            report("seq_number", 32'(seq_number_i), 32'(want.seq_number));
          if (payload_len_i !== want.payload_len)
            report("payload_len", 32'(payload_len_i), 32'(want.payload_len));
          if (last_packet_i !== want.last_packet)
            report("last_packet", 32'(last_packet_i), 32'(want.last_packet));
          if (outcome_i !== want.outcome)
            report("outcome", 32'(outcome_i), 32'(want.outcome));
          if (done_res_i !== want.done_res)
            report("done_res", 32'(done_res_i), 32'(want.done_res));
          if (window_i !== want.window)
            report("window", 32'(window_i), 32'(want.window));
          if (threshold_i !== want.threshold)
            report("threshold", 32'(threshold_i), 32'(want.threshold));
          if (rewinds_i !== want.rewinds)
            report("rewinds", 32'(rewinds_i), 32'(want.rewinds));
        end
      end
      if (in_valid_i && !in_stall_i) sender_step();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// top of the sliding window sender testbench: clock, reset, stimulus and verdict
// depends on swcs_pkg, sliding_window_congestion_sender_core and swcs_checker
`timescale 1ns / 1ps

module tb_top;
  import swcs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_NONE;
  logic [27:0] msg_length_i = '0;
  logic [31:0] now_i = '0;
  logic        rx_received_i = 1'b0;
  logic [7:0]  rx_check_i = '0;
  logic [7:0]  rx_type_i = '0;
  logic [7:0]  rx_seq_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        send_valid_o;
  logic [19:0] packet_index_o;
  logic [7:0]  seq_number_o;
  logic [8:0]  payload_len_o;
  logic        last_packet_o;
  logic [2:0]  outcome_o;
  logic        done_res_o;
  logic [7:0]  window_o;
  logic [6:0]  threshold_o;
  logic [15:0] rewinds_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_TIMEOUT;
  logic [31:0] cfg_data_i = '0;

  int          errors;
  int          words_sent = 0;
  int          words_back = 0;
  int          stall_left = 0;
  logic        quiet = 1'b0;
  logic [31:0] ticks = '0;
  logic [7:0]  ack_guess = '0;

  always #10 clk_i = ~clk_i;

  sliding_window_congestion_sender_core dut (.*);

  swcs_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .msg_length_i, .now_i,
    .rx_received_i, .rx_check_i, .rx_type_i, .rx_seq_i, .out_valid_i(out_valid_o),
    .out_stall_i, .send_valid_i(send_valid_o), .packet_index_i(packet_index_o),
    .seq_number_i(seq_number_o), .payload_len_i(payload_len_o),
    .last_packet_i(last_packet_o), .outcome_i(outcome_o), .done_res_i(done_res_o),
    .window_i(window_o), .threshold_i(threshold_o), .rewinds_i(rewinds_o), .cfg_we_i,
    .cfg_idx_i, .cfg_data_i, .errors_o(errors)
  );

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      words_back++;
      if (outcome_o == OUT_ADVANCE) ack_guess++;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] ack_check(logic [7:0] seq);
    logic [8:0] t;
    t = 9'(ACK_TYPE) + 9'(seq);
    if (t[8]) t = {1'b0, t[7:0]} + 9'd1;
    return ~t[7:0];
  endfunction

  task automatic send_word(cmd_e c, logic [27:0] len, logic rxr, logic [7:0] chk,
                           logic [7:0] typ, logic [7:0] seq);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    if ($urandom_range(0, 15) == 0) ticks = ticks + $urandom;
    else ticks = ticks + $urandom_range(0, 40);
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    msg_length_i  <= len;
    now_i         <= ticks;
    rx_received_i <= rxr;
    rx_check_i    <= chk;
    rx_type_i     <= typ;
    rx_seq_i      <= seq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_noise(cmd_e c);
    send_word(c, 28'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_back != words_sent) @(posedge clk_i);
  endtask

  task automatic start_msg(logic [27:0] len);
    drain();
    ack_guess = '0;
    send_word(CMD_START, len, 1'b0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic pull(logic [31:0] at);
    ticks = at;
    send_noise(CMD_PULL);
  endtask

  task automatic ack(logic [7:0] seq);
    send_word(CMD_RECV, 28'($urandom), 1'b1, ack_check(seq), ACK_TYPE, seq);
  endtask

  task automatic set_regs(logic [31:0] limit, logic [6:0] thr);
    drain();
    repeat (40) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_THRESH;
    cfg_data_i <= {25'($urandom_range(0, 33554431)), thr};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        if ($urandom_range(0, 9) == 0) start_msg(28'($urandom));
        else start_msg(28'($urandom_range(0, 6000)));
      end else if (r < 48) begin
        send_noise(CMD_PULL);
      end else if (r < 88) begin
        r = $urandom_range(0, 9);
        if (r < 7) ack(ack_guess);
        else if (r < 9) ack(ack_guess - 8'd1);
        else ack(8'($urandom));
      end else if (r < 96) begin
        send_noise(CMD_RECV);
      end else begin
        send_noise(CMD_NONE);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_NONE, 28'hFFFFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    pull(32'd0);
    send_word(CMD_RECV, '0, 1'b0, ack_check(8'd0), ACK_TYPE, 8'd0);
    ack(8'd0);
    start_msg(28'd0);
    pull(32'd5);
    start_msg(28'd509);
    pull(32'd10);
    pull(32'd11);
    ack(8'd0);
    start_msg(28'd510);
    pull(32'd20);
    pull(32'd21);
    ack(8'd0);
    pull(32'd30);
    ack(8'd1);
    send_word(CMD_RECV, '0, 1'b1, 8'h00, ACK_TYPE, 8'd0);
    send_word(CMD_RECV, '0, 1'b1, ack_check(8'd1) - 8'd1, 8'd2, 8'd0);
    start_msg(28'hFFFFFFF);
    pull(32'hFFFFFFFF);
    ticks = 32'hFFFF0000;
    ack(8'd7);

    random_phase(80);
    set_regs(32'd0, 7'd1);
    random_phase(80);
    set_regs(32'hFFFFFFFF, 7'd127);
    random_phase(80);
    set_regs(32'd30, 7'd3);
    random_phase(80);
    set_regs($urandom_range(20, 400), 7'($urandom_range(1, 127)));
    quiet = 1'b1;
    random_phase(80);

    drain();
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
